// ----- hw/rtl/ptte_pkg.sv -----
// ----------------------------------------------------------------------------
// ptte_pkg
// Shared types, event codes and helper functions for the pointer to touch
// event translator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptte_pkg;

  localparam int unsigned RunMax = 8;
  localparam int unsigned CntW   = $clog2(RunMax + 1);
  localparam int unsigned TidW   = 16;

  localparam logic [TidW-1:0] TrackingWrap = 16'd60000;

  // event types
  localparam logic [4:0] EVT_SYN = 5'd0;
  localparam logic [4:0] EVT_KEY = 5'd1;
  localparam logic [4:0] EVT_REL = 5'd2;
  localparam logic [4:0] EVT_ABS = 5'd3;

  // event codes
  localparam logic [9:0] C_SYN_REPORT    = 10'h000;
  localparam logic [9:0] C_ABS_X         = 10'h000;
  localparam logic [9:0] C_ABS_Y         = 10'h001;
  localparam logic [9:0] C_MT_SLOT       = 10'h02f;
  localparam logic [9:0] C_MT_POS_X      = 10'h035;
  localparam logic [9:0] C_MT_POS_Y      = 10'h036;
  localparam logic [9:0] C_MT_TRACK      = 10'h039;
  localparam logic [9:0] C_BTN_LEFT      = 10'h110;
  localparam logic [9:0] C_BTN_TOUCH     = 10'h14a;
  localparam logic [9:0] C_GEAR_DOWN     = 10'h150;
  localparam logic [9:0] C_GEAR_UP       = 10'h151;
  localparam logic [9:0] C_REL_HWHEEL    = 10'h006;
  localparam logic [9:0] C_REL_WHEEL     = 10'h008;
  localparam logic [9:0] C_REL_WHEEL_HR  = 10'h00b;
  localparam logic [9:0] C_REL_HWHEEL_HR = 10'h00c;

  localparam logic DEV_TOUCH = 1'b0;
  localparam logic DEV_WHEEL = 1'b1;

  localparam logic signed [31:0] ValLift = -32'sd1;

  typedef struct packed {
    logic               dev;
    logic [4:0]         ev_type;
    logic [9:0]         code;
    logic signed [31:0] value;
  } evt_t;

  typedef struct packed {
    evt_t [RunMax-1:0] ev;
    logic [CntW-1:0]   cnt;
  } run_t;

  function automatic evt_t mk_evt(input logic dev, input logic [4:0] ev_type,
                                  input logic [9:0] code,
                                  input logic signed [31:0] value);
    evt_t e;
    e.dev     = dev;
    e.ev_type = ev_type;
    e.code    = code;
    e.value   = value;
    return e;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ptte_in_stage.sv -----
// ----------------------------------------------------------------------------
// ptte_in_stage
// Input register: holds one event until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptte_in_stage (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // event_code[9:0], event_value[41:10]
  input  wire logic [4:0]  s_axis_tuser,   // event_type[4:0]
  input  wire logic        free_i,
  output logic             proc_o,
  output logic [4:0]       ev_type_o,
  output logic [9:0]       ev_code_o,
  output logic signed [31:0] ev_value_o
);
  import ptte_pkg::*;

  logic               valid_q;
  logic [4:0]         type_q;
  logic [9:0]         code_q;
  logic signed [31:0] value_q;
  logic               take;

  assign proc_o        = valid_q & free_i;
  assign s_axis_tready = ~valid_q | proc_o;
  assign take          = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (proc_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      type_q  <= s_axis_tuser;
      code_q  <= s_axis_tdata[9:0];
      value_q <= s_axis_tdata[41:10];
    end
  end

  assign ev_type_o  = type_q;
  assign ev_code_o  = code_q;
  assign ev_value_o = value_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ptte_core.sv -----
// ----------------------------------------------------------------------------
// ptte_core
// Translator state and run builder: updates pointer, button and wheel state
// and forms the list of output words for one input event.
// ----------------------------------------------------------------------------
`default_nettype none

module ptte_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               proc_i,
  input  wire logic [4:0]         ev_type_i,
  input  wire logic [9:0]         ev_code_i,
  input  wire logic signed [31:0] ev_value_i,
  output ptte_pkg::run_t          run_o
);
  import ptte_pkg::*;

  logic signed [31:0] x_q, x_d, y_q, y_d;
  logic               pressed_q, pressed_d, moved_q, moved_d;
  logic signed [31:0] wacc_q, wacc_d, hacc_q, hacc_d;
  logic signed [31:0] wfine_q, wfine_d, hfine_q, hfine_d;
  logic [TidW-1:0]    tid_q, tid_d;

  logic               w1_en, w2_en;
  logic [9:0]         w1_code, w2_code;
  logic signed [31:0] w1_val, w2_val;
  evt_t [3:0]         w1_seq, w2_seq;
  logic               is_button, val_nz;

  always_comb begin
    w1_en   = (wfine_q != '0) | (wacc_q != '0);
    w1_code = (wfine_q != '0) ? C_REL_WHEEL_HR : C_REL_WHEEL;
    w1_val  = (wfine_q != '0) ? wfine_q : wacc_q;
    w2_en   = (hfine_q != '0) | (hacc_q != '0);
    w2_code = (hfine_q != '0) ? C_REL_HWHEEL_HR : C_REL_HWHEEL;
    w2_val  = (hfine_q != '0) ? hfine_q : hacc_q;
    w1_seq[0] = mk_evt(DEV_WHEEL, EVT_ABS, C_ABS_X, x_q);
    w1_seq[1] = mk_evt(DEV_WHEEL, EVT_ABS, C_ABS_Y, y_q);
    w1_seq[2] = mk_evt(DEV_WHEEL, EVT_REL, w1_code, w1_val);
    w1_seq[3] = mk_evt(DEV_WHEEL, EVT_SYN, C_SYN_REPORT, '0);
    w2_seq[0] = mk_evt(DEV_WHEEL, EVT_ABS, C_ABS_X, x_q);
    w2_seq[1] = mk_evt(DEV_WHEEL, EVT_ABS, C_ABS_Y, y_q);
    w2_seq[2] = mk_evt(DEV_WHEEL, EVT_REL, w2_code, w2_val);
    w2_seq[3] = mk_evt(DEV_WHEEL, EVT_SYN, C_SYN_REPORT, '0);
  end

  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    pressed_d = pressed_q;
    moved_d   = moved_q;
    wacc_d    = wacc_q;
    hacc_d    = hacc_q;
    wfine_d   = wfine_q;
    hfine_d   = hfine_q;
    tid_d     = tid_q;
    run_o     = '0;
    is_button = (ev_code_i == C_BTN_LEFT) | (ev_code_i == C_BTN_TOUCH);
    val_nz    = (ev_value_i != '0);

    case (ev_type_i)
      EVT_ABS: begin
        if (ev_code_i == C_ABS_X) begin
          x_d     = ev_value_i;
          moved_d = 1'b1;
        end else if (ev_code_i == C_ABS_Y) begin
          y_d     = ev_value_i;
          moved_d = 1'b1;
        end
      end
      EVT_KEY: begin
        if (is_button) begin
          if (val_nz) begin
            pressed_d    = 1'b1;
            moved_d      = 1'b0;
            run_o.ev[0]  = mk_evt(DEV_TOUCH, EVT_ABS, C_MT_SLOT, '0);
            run_o.ev[1]  = mk_evt(DEV_TOUCH, EVT_ABS, C_MT_TRACK,
                                  {{(32-TidW){1'b0}}, tid_q});
            run_o.ev[2]  = mk_evt(DEV_TOUCH, EVT_ABS, C_MT_POS_X, x_q);
            run_o.ev[3]  = mk_evt(DEV_TOUCH, EVT_ABS, C_MT_POS_Y, y_q);
            run_o.ev[4]  = mk_evt(DEV_TOUCH, EVT_KEY, C_BTN_TOUCH, 32'sd1);
            run_o.ev[5]  = mk_evt(DEV_TOUCH, EVT_SYN, C_SYN_REPORT, '0);
            run_o.cnt    = CntW'(6);
          end else if (pressed_q) begin
            pressed_d    = 1'b0;
            moved_d      = 1'b0;
            run_o.ev[0]  = mk_evt(DEV_TOUCH, EVT_ABS, C_MT_SLOT, '0);
            run_o.ev[1]  = mk_evt(DEV_TOUCH, EVT_ABS, C_MT_TRACK, ValLift);
            run_o.ev[2]  = mk_evt(DEV_TOUCH, EVT_KEY, C_BTN_TOUCH, '0);
            run_o.ev[3]  = mk_evt(DEV_TOUCH, EVT_SYN, C_SYN_REPORT, '0);
            run_o.cnt    = CntW'(4);
            // id stays within 1..wrap, so the modulo is a single compare
            tid_d = (tid_q >= TrackingWrap) ? TidW'(1) : tid_q + TidW'(1);
          end
        end else if (val_nz && !pressed_q) begin
          if (ev_code_i == C_GEAR_UP) begin
            wacc_d = sat_add(wacc_q, 32'sd1);
          end else if (ev_code_i == C_GEAR_DOWN) begin
            wacc_d = sat_add(wacc_q, -32'sd1);
          end
        end
      end
      EVT_REL: begin
        if (!pressed_q) begin
          case (ev_code_i)
            C_REL_WHEEL:     wacc_d  = sat_add(wacc_q, ev_value_i);
            C_REL_HWHEEL:    hacc_d  = sat_add(hacc_q, ev_value_i);
            C_REL_WHEEL_HR:  wfine_d = sat_add(wfine_q, ev_value_i);
            C_REL_HWHEEL_HR: hfine_d = sat_add(hfine_q, ev_value_i);
            default: ;
          endcase
        end
      end
      EVT_SYN: begin
        if (ev_code_i == C_SYN_REPORT) begin
          if (pressed_q && moved_q) begin
            run_o.ev[0] = mk_evt(DEV_TOUCH, EVT_ABS, C_MT_SLOT, '0);
            run_o.ev[1] = mk_evt(DEV_TOUCH, EVT_ABS, C_MT_POS_X, x_q);
            run_o.ev[2] = mk_evt(DEV_TOUCH, EVT_ABS, C_MT_POS_Y, y_q);
            run_o.ev[3] = mk_evt(DEV_TOUCH, EVT_SYN, C_SYN_REPORT, '0);
            run_o.cnt   = CntW'(4);
            moved_d     = 1'b0;
          end
          if (!pressed_q) begin
            // a flush clears both resolutions of both wheels
            wacc_d  = '0;
            wfine_d = '0;
            hacc_d  = '0;
            hfine_d = '0;
            for (int i = 0; i < 4; i++) begin
              run_o.ev[i]     = w1_en ? w1_seq[i] : w2_seq[i];
              run_o.ev[i + 4] = (w1_en && w2_en) ? w2_seq[i] : '0;
            end
            run_o.cnt = {w1_en & w2_en, w1_en ^ w2_en, 2'b00};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      pressed_q <= 1'b0;
      moved_q   <= 1'b0;
      wacc_q    <= '0;
      hacc_q    <= '0;
      wfine_q   <= '0;
      hfine_q   <= '0;
      tid_q     <= TidW'(1);
    end else if (proc_i) begin
      x_q       <= x_d;
      y_q       <= y_d;
      pressed_q <= pressed_d;
      moved_q   <= moved_d;
      wacc_q    <= wacc_d;
      hacc_q    <= hacc_d;
      wfine_q   <= wfine_d;
      hfine_q   <= hfine_d;
      tid_q     <= tid_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ptte_run.sv -----
// ----------------------------------------------------------------------------
// ptte_run
// Result register: holds one run of output words and shifts it out one
// word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ptte_run (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire ptte_pkg::run_t run_i,
  output logic              free_o,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [47:0]       m_axis_tdata,   // out_code[9:0], out_value[41:10]
  output logic [5:0]        m_axis_tuser,   // out_device[0], out_type[5:1]
  output logic              m_axis_tlast
);
  import ptte_pkg::*;

  evt_t [RunMax-1:0] ev_q;
  logic [CntW-1:0]   cnt_q;
  logic              take;

  assign take          = m_axis_tvalid & m_axis_tready;
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tlast  = (cnt_q == CntW'(1));
  assign free_o        = (cnt_q == '0) | (m_axis_tlast & m_axis_tready);
  assign m_axis_tdata  = {6'b0, ev_q[0].value, ev_q[0].code};
  assign m_axis_tuser  = {ev_q[0].ev_type, ev_q[0].dev};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= run_i.cnt;
    end else if (take) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ev_q <= run_i.ev;
    end else if (take) begin
      for (int i = 0; i < RunMax - 1; i++) begin
        ev_q[i] <= ev_q[i + 1];
      end
      ev_q[RunMax-1] <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pointer_to_touch_event_translator_top.sv -----
// ----------------------------------------------------------------------------
// pointer_to_touch_event_translator_top
// Turns absolute pointer, button and wheel events into touch and wheel pointer event runs.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one input event per word, event_type in tuser, code and value
//   in tdata. m_axis: output words, device and type in tuser, code and
//   value in tdata, tlast on the final word caused by one input event.
//   an input event yields no words, or a run of 4, 6 or 8 words.
//   path: an input word passes the input register, then the result
//   register, before the first word of its run is offered.
//   throughput: an event that yields no words leaves the result register
//   empty; otherwise the result register hands out one word per cycle
//   while m_axis_tready is high. the next run is loaded in the cycle its
//   predecessor's last word is taken, so runs follow without gaps.
//   reset: pointer position, flags and wheel totals clear, tracking id
//   starts at 1, both channels go empty.
//   stall: while the receiver holds m_axis_tready low the current word
//   holds; one more input word is buffered, then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_to_touch_event_translator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // event_code[9:0], event_value[41:10]
  input  wire logic [4:0]  s_axis_tuser,   // event_type[4:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // out_code[9:0], out_value[41:10]
  output logic [5:0]       m_axis_tuser,   // out_device[0], out_type[5:1]
  output logic             m_axis_tlast
);
  import ptte_pkg::*;

  logic               free;
  logic               proc;
  logic [4:0]         ev_type;
  logic [9:0]         ev_code;
  logic signed [31:0] ev_value;
  run_t               run;

  ptte_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .free_i       (free),
    .proc_o       (proc),
    .ev_type_o    (ev_type),
    .ev_code_o    (ev_code),
    .ev_value_o   (ev_value)
  );

  ptte_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .proc_i    (proc),
    .ev_type_i (ev_type),
    .ev_code_i (ev_code),
    .ev_value_i(ev_value),
    .run_o     (run)
  );

  ptte_run u_run (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (proc),
    .run_i        (run),
    .free_o       (free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ptte_checker.sv -----
// ----------------------------------------------------------------------------
// ptte_checker
// Port-level checks of the translator's stream behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module ptte_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [5:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import ptte_pkg::*;

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // every run closes with a sync report
  a_last_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser[5:1] == EVT_SYN && m_axis_tdata[9:0] == C_SYN_REPORT)
    else $error("run does not end with a sync report");

  // a run goes out without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a run");

  // input backpressure only while output holds words
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

endmodule

bind pointer_to_touch_event_translator_top ptte_checker u_ptte_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
